FILE: rtl/kmst_pkg.sv
// kmst_pkg: constants, state encoding and result type for the kruskal spanning tree block
// no dependencies
package kmst_pkg;

   localparam int MAX_VERTICES = 32;
   localparam int WEIGHT_BITS  = 16;
   localparam int CELLS        = MAX_VERTICES * MAX_VERTICES;
   localparam int ADDR_W       = $clog2(CELLS);
   localparam int VERT_W       = $clog2(MAX_VERTICES);
   localparam int SIDE_W       = $clog2(MAX_VERTICES + 1);
   localparam int TOTAL_W      = $clog2(CELLS + 1);
   localparam int COST_W       = $clog2((MAX_VERTICES - 1) * ((1 << WEIGHT_BITS) - 1) + 1);
   localparam int KEY_W        = WEIGHT_BITS + ADDR_W;
   localparam int VC_W         = 7;
   localparam int VC_RESET     = 32;
   localparam int OUT_VERT_W   = 6;
   localparam int OUT_WEIGHT_W = 16;
   localparam int OUT_COST_W   = 22;

   typedef enum logic [3:0] {
      ST_LOAD,
      ST_INIT,
      ST_SCAN,
      ST_FA_RD,
      ST_FA_CHK,
      ST_FB_RD,
      ST_FB_CHK,
      ST_UNION,
      ST_PUSH,
      ST_FINAL
   } state_type;

   typedef struct packed {
      logic                    edge_valid;
      logic [OUT_VERT_W-1:0]   from_vertex;
      logic [OUT_VERT_W-1:0]   to_vertex;
      logic [OUT_WEIGHT_W-1:0] chosen_weight;
      logic [OUT_COST_W-1:0]   cost_so_far;
      logic                    last_result;
   } result_type;

endpackage

FILE: rtl/kmst_req_if.sv
// kmst_req_if: input channel carrying one matrix entry per transaction
// depends on kmst_pkg
interface kmst_req_if;
   logic                             valid;
   logic                             ready;
   logic [kmst_pkg::WEIGHT_BITS-1:0] edge_weight;

   modport source (output valid, output edge_weight, input ready);
   modport sink (input valid, input edge_weight, output ready);
endinterface

FILE: rtl/kmst_rsp_if.sv
// kmst_rsp_if: result channel carrying one selected edge per transaction
// depends on kmst_pkg
interface kmst_rsp_if;
   logic                              valid;
   logic                              ready;
   logic                              edge_valid;
   logic [kmst_pkg::OUT_VERT_W-1:0]   from_vertex;
   logic [kmst_pkg::OUT_VERT_W-1:0]   to_vertex;
   logic [kmst_pkg::OUT_WEIGHT_W-1:0] chosen_weight;
   logic [kmst_pkg::OUT_COST_W-1:0]   cost_so_far;
   logic                              last_result;

   modport source (output valid, output edge_valid, output from_vertex, output to_vertex,
                   output chosen_weight, output cost_so_far, output last_result, input ready);
   modport sink (input valid, input edge_valid, input from_vertex, input to_vertex,
                 input chosen_weight, input cost_so_far, input last_result, output ready);
endinterface

FILE: rtl/kmst_ram.sv
// kmst_ram: generic single write, single read memory with registered read data
// no dependencies
module kmst_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

FILE: rtl/kruskal_minimum_spanning_tree.sv
// kruskal minimum spanning tree over a streamed adjacency matrix
// loading takes one weight transaction per cycle; after the last of n*n entries the block
// scans the weight memory once per candidate edge (one read a cycle) and walks the parent
// memory with a read state and a check state per hop; no input is taken until the final
// result is loaded into the output register
// synchronous active high reset: vertex count 32, load position zero, no result pending
module kruskal_minimum_spanning_tree (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write_enable,
   input  logic [kmst_pkg::VC_W-1:0] csr_write_data,
   kmst_req_if.sink               req_chan,
   kmst_rsp_if.source             rsp_chan
);
   import kmst_pkg::*;

   state_type state_ff, state_in;

   logic [VC_W-1:0]    vc_ff;
   logic [SIDE_W-1:0]  side;
   logic [TOTAL_W-1:0] total;
   logic [ADDR_W-1:0]  load_pos_ff, load_pos_in;
   logic               load_done;

   logic [VERT_W-1:0]  init_ff, init_in;
   logic [TOTAL_W-1:0] scan_ff, scan_in;
   logic [VERT_W-1:0]  row_ff, row_in, col_ff, col_in;
   logic               rd_v_ff, rd_v_in;
   logic [ADDR_W-1:0]  rd_idx_ff;
   logic [VERT_W-1:0]  rd_row_ff, rd_col_ff;
   logic [WEIGHT_BITS-1:0] wq;
   logic [KEY_W-1:0]   rd_key;
   logic               cand;

   logic [KEY_W-1:0]   best_key_ff, best_key_in, last_key_ff, last_key_in;
   logic               best_found_ff, best_found_in, have_last_ff, have_last_in;
   logic [VERT_W-1:0]  best_row_ff, best_row_in, best_col_ff, best_col_in;
   logic [VERT_W-1:0]  cur_ff, cur_in, ra_ff, ra_in, rb_ff, rb_in, pq;
   logic [COST_W-1:0]  cost_ff, cost_in;
   logic [SIDE_W-1:0]  count_ff, count_in;
   logic               pend_v_ff, pend_v_in;
   result_type         pend_ff, pend_in;
   logic               out_v_ff, out_v_in;
   result_type         out_ff, out_in;
   logic               out_free, scan_end, start_scan;

   logic               w_wr;
   logic               p_wr;
   logic [VERT_W-1:0]  p_waddr, p_wdata, p_raddr;

   always_comb begin
      if (vc_ff < VC_W'(2)) begin
         side = SIDE_W'(2);
      end else if (vc_ff > VC_W'(MAX_VERTICES)) begin
         side = SIDE_W'(MAX_VERTICES);
      end else begin
         side = SIDE_W'(vc_ff);
      end
   end
   assign total = TOTAL_W'(side * side);

   assign w_wr      = (state_ff == ST_LOAD) && req_chan.valid && req_chan.ready;
   assign load_done = w_wr && ((TOTAL_W'(load_pos_ff) + TOTAL_W'(1)) == total);

   kmst_ram #(.WIDTH(WEIGHT_BITS), .DEPTH(CELLS)) u_weight (
      .clock   (clock),
      .wr_en   (w_wr),
      .wr_addr (load_pos_ff),
      .wr_data (req_chan.edge_weight[WEIGHT_BITS-1:0]),
      .rd_addr (scan_ff[ADDR_W-1:0]),
      .rd_data (wq)
   );

   kmst_ram #(.WIDTH(VERT_W), .DEPTH(MAX_VERTICES)) u_parent (
      .clock   (clock),
      .wr_en   (p_wr),
      .wr_addr (p_waddr),
      .wr_data (p_wdata),
      .rd_addr (p_raddr),
      .rd_data (pq)
   );

   assign out_free = !out_v_ff || rsp_chan.ready;
   assign scan_end = (scan_ff == total) && !rd_v_ff;
   assign rd_key   = {wq, rd_idx_ff};
   assign cand     = rd_v_ff && (wq != '0) && (!have_last_ff || rd_key > last_key_ff)
                     && (!best_found_ff || rd_key < best_key_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_LOAD: begin
            if (load_done) state_in = ST_INIT;
         end
         ST_INIT: begin
            if (init_ff == VERT_W'(MAX_VERTICES - 1)) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (scan_end) state_in = best_found_ff ? ST_FA_RD : ST_FINAL;
         end
         ST_FA_RD:  state_in = ST_FA_CHK;
         ST_FA_CHK: state_in = (pq == cur_ff) ? ST_FB_RD : ST_FA_RD;
         ST_FB_RD:  state_in = ST_FB_CHK;
         ST_FB_CHK: begin
            if (pq == cur_ff) state_in = ST_UNION;
            else state_in = ST_FB_RD;
         end
         ST_UNION: state_in = (ra_ff == rb_ff) ? ST_SCAN : ST_PUSH;
         ST_PUSH: begin
            if (out_free) begin
               state_in = (count_ff == side - SIDE_W'(1)) ? ST_FINAL : ST_SCAN;
            end
         end
         ST_FINAL: begin
            if (out_free) state_in = ST_LOAD;
         end
         default: state_in = ST_LOAD;
      endcase
   end

   // datapath and outputs
   always_comb begin
      load_pos_in   = load_pos_ff;
      init_in       = init_ff;
      scan_in       = scan_ff;
      row_in        = row_ff;
      col_in        = col_ff;
      rd_v_in       = 1'b0;
      best_key_in   = best_key_ff;
      best_found_in = best_found_ff;
      best_row_in   = best_row_ff;
      best_col_in   = best_col_ff;
      last_key_in   = last_key_ff;
      have_last_in  = have_last_ff;
      cur_in        = cur_ff;
      ra_in         = ra_ff;
      rb_in         = rb_ff;
      cost_in       = cost_ff;
      count_in      = count_ff;
      pend_v_in     = pend_v_ff;
      pend_in       = pend_ff;
      out_v_in      = out_v_ff && !rsp_chan.ready;
      out_in        = out_ff;
      p_wr          = 1'b0;
      p_waddr       = init_ff;
      p_wdata       = init_ff;
      p_raddr       = cur_ff;
      req_chan.ready = (state_ff == ST_LOAD);
      start_scan    = (state_in == ST_SCAN) && (state_ff != ST_SCAN);

      case (state_ff)
         ST_LOAD: begin
            if (w_wr) load_pos_in = load_pos_ff + ADDR_W'(1);
            if (load_done) begin
               load_pos_in  = '0;
               init_in      = '0;
               cost_in      = '0;
               count_in     = '0;
               have_last_in = 1'b0;
               pend_v_in    = 1'b0;
            end
         end
         ST_INIT: begin
            p_wr    = 1'b1;
            init_in = init_ff + VERT_W'(1);
         end
         ST_SCAN: begin
            if (scan_ff != total) begin
               rd_v_in = 1'b1;
               scan_in = scan_ff + TOTAL_W'(1);
               if ({1'b0, col_ff} == side - SIDE_W'(1)) begin
                  col_in = '0;
                  row_in = row_ff + VERT_W'(1);
               end else begin
                  col_in = col_ff + VERT_W'(1);
               end
            end
            if (cand) begin
               best_found_in = 1'b1;
               best_key_in   = rd_key;
               best_row_in   = rd_row_ff;
               best_col_in   = rd_col_ff;
            end
            if (scan_end) begin
               cur_in       = best_row_ff;
               last_key_in  = best_key_ff;
               have_last_in = 1'b1;
            end
         end
         ST_FA_CHK: begin
            if (pq == cur_ff) begin
               ra_in  = cur_ff;
               cur_in = best_col_ff;
            end else begin
               cur_in = pq;
            end
         end
         ST_FB_CHK: begin
            if (pq == cur_ff) rb_in = cur_ff;
            else cur_in = pq;
         end
         ST_UNION: begin
            if (ra_ff != rb_ff) begin
               p_wr     = 1'b1;
               p_waddr  = ra_ff;
               p_wdata  = rb_ff;
               cost_in  = cost_ff + COST_W'(best_key_ff[KEY_W-1:ADDR_W]);
               count_in = count_ff + SIDE_W'(1);
            end
         end
         ST_PUSH: begin
            if (out_free) begin
               if (pend_v_ff) begin
                  out_v_in = 1'b1;
                  out_in   = pend_ff;
               end
               pend_v_in             = 1'b1;
               pend_in.edge_valid    = 1'b1;
               pend_in.from_vertex   = OUT_VERT_W'(best_row_ff);
               pend_in.to_vertex     = OUT_VERT_W'(best_col_ff);
               pend_in.chosen_weight = OUT_WEIGHT_W'(best_key_ff[KEY_W-1:ADDR_W]);
               pend_in.cost_so_far   = OUT_COST_W'(cost_ff);
               pend_in.last_result   = 1'b0;
            end
         end
         ST_FINAL: begin
            if (out_free) begin
               out_v_in = 1'b1;
               if (pend_v_ff) begin
                  out_in             = pend_ff;
                  out_in.last_result = 1'b1;
               end else begin
                  out_in             = '0;
                  out_in.last_result = 1'b1;
               end
               pend_v_in = 1'b0;
            end
         end
         default: begin
         end
      endcase

      if (start_scan) begin
         scan_in       = '0;
         row_in        = '0;
         col_in        = '0;
         best_found_in = 1'b0;
      end
      if (csr_write_enable) load_pos_in = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_LOAD;
         vc_ff       <= VC_W'(VC_RESET);
         load_pos_ff <= '0;
         out_v_ff    <= 1'b0;
         pend_v_ff   <= 1'b0;
         rd_v_ff     <= 1'b0;
      end else begin
         state_ff    <= state_in;
         if (csr_write_enable) vc_ff <= csr_write_data;
         load_pos_ff <= load_pos_in;
         out_v_ff    <= out_v_in;
         pend_v_ff   <= pend_v_in;
         rd_v_ff     <= rd_v_in;
      end
   end

   always_ff @(posedge clock) begin
      init_ff       <= init_in;
      scan_ff       <= scan_in;
      row_ff        <= row_in;
      col_ff        <= col_in;
      rd_idx_ff     <= scan_ff[ADDR_W-1:0];
      rd_row_ff     <= row_ff;
      rd_col_ff     <= col_ff;
      best_key_ff   <= best_key_in;
      best_found_ff <= best_found_in;
      best_row_ff   <= best_row_in;
      best_col_ff   <= best_col_in;
      last_key_ff   <= last_key_in;
      have_last_ff  <= have_last_in;
      cur_ff        <= cur_in;
      ra_ff         <= ra_in;
      rb_ff         <= rb_in;
      cost_ff       <= cost_in;
      count_ff      <= count_in;
      pend_ff       <= pend_in;
      out_ff        <= out_in;
   end

   assign rsp_chan.valid         = out_v_ff;
   assign rsp_chan.edge_valid    = out_ff.edge_valid;
   assign rsp_chan.from_vertex   = out_ff.from_vertex;
   assign rsp_chan.to_vertex     = out_ff.to_vertex;
   assign rsp_chan.chosen_weight = out_ff.chosen_weight;
   assign rsp_chan.cost_so_far   = out_ff.cost_so_far;
   assign rsp_chan.last_result   = out_ff.last_result;

`ifndef NO_ASSERTIONS
   a_union_distinct_roots: assert property (@(posedge clock) disable iff (reset)
      p_wr && (state_ff == ST_UNION) |-> ra_ff != rb_ff)
      else $error("parent link written for equal roots");
   a_no_input_while_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_LOAD) |-> !req_chan.ready)
      else $error("input taken outside loading");
   a_edge_has_weight: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.edge_valid |-> rsp_chan.chosen_weight != '0)
      else $error("selected edge with zero weight");
   a_empty_result_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.edge_valid |-> rsp_chan.last_result
      && (rsp_chan.cost_so_far == '0))
      else $error("empty result malformed");
`endif
endmodule

FILE: bench/tb_kruskal_minimum_spanning_tree.sv
// tb_kruskal_minimum_spanning_tree: drives adjacency matrices and vertex counts into the
// spanning tree block and checks every result against a local kruskal predictor or a fixed expected result
// depends on kmst_pkg, kmst_req_if, kmst_rsp_if and kruskal_minimum_spanning_tree
module tb_kruskal_minimum_spanning_tree;
   import kmst_pkg::*;

   typedef struct {
      bit          is_csr;
      logic [15:0] value;
      bit          typed;
      result_type  want;
   } stim_row_type;

   logic clock;
   logic reset;
   logic csr_write_enable;
   logic [VC_W-1:0] csr_write_data;

   kmst_req_if req_chan();
   kmst_rsp_if rsp_chan();

   kruskal_minimum_spanning_tree u_top (
      .clock(clock),
      .reset(reset),
      .csr_write_enable(csr_write_enable),
      .csr_write_data(csr_write_data),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan)
   );

   logic [15:0] cell_weights [CELLS];
   int          scan_order [CELLS];
   int          link [MAX_VERTICES];
   int          cells_loaded;
   int          side_reg;
   result_type  pending_edges [$];
   int          fail_count;
   bit          idle_enable;
   bit          hold_request;
   bit          hold_done;
   int          hold_left;
   int          ready_left;
   int          items_sent;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic int root_of(input int v);
      int r;
      int w;
      int nxt;
      r = v;
      while (link[r] != r) r = link[r];
      w = v;
      while (link[w] != w) begin
         nxt = link[w];
         link[w] = r;
         w = nxt;
      end
      return r;
   endfunction

   function automatic void build_tree(input int n, ref result_type found [$]);
      int total;
      int pos;
      int idx;
      int ra;
      int rb;
      int cost;
      result_type r;
      total = n * n;
      cost = 0;
      for (int k = 0; k < total; k++) begin
         pos = k;
         while (pos > 0 && cell_weights[scan_order[pos-1]] > cell_weights[k]) begin
            scan_order[pos] = scan_order[pos-1];
            pos--;
         end
         scan_order[pos] = k;
      end
      for (int v = 0; v < MAX_VERTICES; v++) link[v] = v;
      for (int k = 0; k < total; k++) begin
         idx = scan_order[k];
         if (cell_weights[idx] == 0) continue;
         ra = root_of(idx / n);
         rb = root_of(idx % n);
         if (ra == rb) continue;
         link[ra] = rb;
         cost += int'(cell_weights[idx]);
         r.edge_valid    = 1'b1;
         r.from_vertex   = OUT_VERT_W'(idx / n);
         r.to_vertex     = OUT_VERT_W'(idx % n);
         r.chosen_weight = cell_weights[idx];
         r.cost_so_far   = OUT_COST_W'(cost);
         r.last_result   = 1'b0;
         found.push_back(r);
      end
      if (found.size() == 0) begin
         r = '0;
         r.last_result = 1'b1;
         found.push_back(r);
      end else begin
         found[found.size()-1].last_result = 1'b1;
      end
   endfunction

   function automatic void load_cell(input logic [15:0] w, input bit typed,
                                     input result_type want);
      int n;
      result_type found [$];
      n = side_reg < 2 ? 2 : (side_reg > MAX_VERTICES ? MAX_VERTICES : side_reg);
      if (cells_loaded >= n * n) cells_loaded = 0;
      cell_weights[cells_loaded] = w;
      cells_loaded++;
      if (cells_loaded < n * n) return;
      cells_loaded = 0;
      build_tree(n, found);
      if (typed) pending_edges.push_back(want);
      else foreach (found[i]) pending_edges.push_back(found[i]);
   endfunction

   task automatic send_weight(input logic [15:0] w, input bit typed, input result_type want);
      if (idle_enable && $urandom_range(0, 3) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.edge_weight <= w;
      do @(posedge clock); while (!req_chan.ready);
      load_cell(w, typed, want);
      items_sent++;
   endtask

   task automatic write_side(input logic [VC_W-1:0] v);
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (pending_edges.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= v;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      side_reg = int'(v);
      cells_loaded = 0;
   endtask

   // long receiver hold-off, started once on the first result offered after the request
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
         hold_done <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end else if (hold_request && !hold_done && rsp_chan.valid) begin
         hold_left <= 400;
         hold_done <= 1'b1;
      end
   end

   // result side: random stalls, field checks
   always @(posedge clock) begin
      result_type want;
      if (!reset) begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (pending_edges.size() == 0) begin
               $display("%0t unexpected result transaction", $time);
               fail_count++;
            end else begin
               want = pending_edges.pop_front();
               if (rsp_chan.edge_valid !== want.edge_valid) begin
                  $display("%0t edge_valid exp %0d got %0d", $time, want.edge_valid,
                           rsp_chan.edge_valid);
                  fail_count++;
               end
               if (rsp_chan.from_vertex !== want.from_vertex) begin
                  $display("%0t from_vertex exp %0d got %0d", $time, want.from_vertex,
                           rsp_chan.from_vertex);
                  fail_count++;
               end
               if (rsp_chan.to_vertex !== want.to_vertex) begin
                  $display("%0t to_vertex exp %0d got %0d", $time, want.to_vertex,
                           rsp_chan.to_vertex);
                  fail_count++;
               end
               if (rsp_chan.chosen_weight !== want.chosen_weight) begin
                  $display("%0t chosen_weight exp %0d got %0d", $time, want.chosen_weight,
                           rsp_chan.chosen_weight);
                  fail_count++;
               end
               if (rsp_chan.cost_so_far !== want.cost_so_far) begin
                  $display("%0t cost_so_far exp %0d got %0d", $time, want.cost_so_far,
                           rsp_chan.cost_so_far);
                  fail_count++;
               end
               if (rsp_chan.last_result !== want.last_result) begin
                  $display("%0t last_result exp %0d got %0d", $time, want.last_result,
                           rsp_chan.last_result);
                  fail_count++;
               end
            end
         end
         if (hold_left > 0) begin
            rsp_chan.ready <= 1'b0;
         end else if (ready_left > 0) begin
            ready_left--;
         end else if (idle_enable && $urandom_range(0, 2) == 0) begin
            rsp_chan.ready <= 1'b0;
            ready_left = $urandom_range(1, 7);
         end else begin
            rsp_chan.ready <= 1'b1;
            ready_left = $urandom_range(0, 10);
         end
      end
   end

   initial begin
      #100_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      stim_row_type rows [$];
      stim_row_type row;
      result_type none;
      result_type empty_tree;
      result_type heavy_edge;
      int n;
      int pick;
      int count;
      int span;
      logic [15:0] w;

      none = '0;
      empty_tree = '0;
      empty_tree.last_result = 1'b1;
      heavy_edge = '{1'b1, 6'd0, 6'd1, 16'hFFFF, 22'd65535, 1'b1};

      reset = 1'b1;
      csr_write_enable = 1'b0;
      csr_write_data = '0;
      req_chan.valid = 1'b0;
      req_chan.edge_weight = '0;
      rsp_chan.ready = 1'b0;
      fail_count = 0;
      idle_enable = 1'b1;
      hold_request = 1'b0;
      ready_left = 0;
      items_sent = 0;
      side_reg = VC_RESET;
      cells_loaded = 0;
      for (int v = 0; v < MAX_VERTICES; v++) link[v] = v;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: saturated low side, empty graph, heaviest edge, self loops, ties
      rows.push_back('{1, 16'd0, 0, none});
      rows.push_back('{0, 16'd0, 0, none});
      rows.push_back('{0, 16'd0, 0, none});
      rows.push_back('{0, 16'd0, 0, none});
      rows.push_back('{0, 16'd0, 1, empty_tree});
      rows.push_back('{0, 16'd0, 0, none});
      rows.push_back('{0, 16'hFFFF, 0, none});
      rows.push_back('{0, 16'd0, 0, none});
      rows.push_back('{0, 16'd0, 1, heavy_edge});
      rows.push_back('{1, 16'd1, 0, none});
      rows.push_back('{0, 16'd5, 0, none});
      rows.push_back('{0, 16'd0, 0, none});
      rows.push_back('{0, 16'd0, 0, none});
      rows.push_back('{0, 16'd5, 1, empty_tree});
      rows.push_back('{1, 16'd3, 0, none});
      rows.push_back('{0, 16'd2, 0, none});
      rows.push_back('{0, 16'd1, 0, none});
      rows.push_back('{0, 16'd1, 0, none});
      rows.push_back('{0, 16'd1, 0, none});
      rows.push_back('{0, 16'd0, 0, none});
      rows.push_back('{0, 16'd3, 0, none});
      rows.push_back('{0, 16'd1, 0, none});
      rows.push_back('{0, 16'd3, 0, none});
      rows.push_back('{0, 16'd7, 0, none});

      foreach (rows[i]) begin
         row = rows[i];
         if (row.is_csr) write_side(row.value[VC_W-1:0]);
         else send_weight(row.value, row.typed, row.want);
      end

      // random matrices, mostly small sides; large settings are loaded partly then dropped
      // the first pair of matrices goes back to back under a long receiver hold-off
      count = 0;
      while (items_sent < 420) begin
         pick = $urandom_range(0, 19);
         if (count == 0) n = 8;
         else if (pick == 0) n = 127;
         else if (pick == 1) n = 64;
         else if (pick == 2) n = $urandom_range(0, 1);
         else n = $urandom_range(2, 6);
         write_side(n[VC_W-1:0]);
         if (items_sent > 340) idle_enable = 1'b0;
         span = (n > MAX_VERTICES) ? $urandom_range(3, 40) : (n < 2 ? 4 : n * n);
         if (count == 0) begin
            hold_request = 1'b1;
            span = 2 * span;
         end
         count++;
         pick = $urandom_range(0, 3);
         for (int k = 0; k < span; k++) begin
            case (pick)
               0: w = 16'($urandom_range(0, 65535));
               1: w = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom_range(1, 4));
               2: w = ($urandom_range(0, 1) == 0) ? 16'hFFFF : 16'($urandom_range(0, 65535));
               default: w = ($urandom_range(0, 2) == 0) ? 16'd0 : 16'($urandom_range(1, 300));
            endcase
            send_weight(w, 1'b0, none);
         end
      end

      req_chan.valid <= 1'b0;
      while (pending_edges.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (fail_count == 0 && pending_edges.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
